### rtl/core/pbrle_pkg.sv
// Types and constants for the PackBits run-length encoder core.
// No dependencies; imported by pbrle_step and packbits_rle_encoder_core.
`timescale 1ns / 1ps
`default_nettype none

package pbrle_pkg;

    localparam int unsigned POS_W = 21;
    localparam logic [7:0]  RUN_MAX = 8'd128;

    typedef enum logic [1:0] {
        MODE_BASE    = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_RUN     = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] out_pos;
        logic [7:0]       out_byte;
        logic             out_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]       group_value;
        logic [7:0]       group_count;
        mode_t            coding_mode;
        logic [7:0]       literal_length;
        logic [POS_W-1:0] literal_header_pos;
        logic [POS_W-1:0] write_pos;
    } enc_state_t;

    // Writes caused by one input byte: up to four, in order from index 0
    typedef struct packed {
        out_item_t [3:0] wr;
        logic [2:0]      num;
    } step_res_t;

    // One closed group: new state plus its two writes
    typedef struct packed {
        enc_state_t st;
        out_item_t  w0;
        out_item_t  w1;
    } close_t;

endpackage

`default_nettype wire

### rtl/core/pbrle_step.sv
// Combinational next-state and write generation for one input byte.
// Depends on pbrle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbrle_step (
    input  wire pbrle_pkg::enc_state_t cur,
    input  wire pbrle_pkg::in_item_t   item,
    output pbrle_pkg::enc_state_t      nxt,
    output pbrle_pkg::step_res_t       res
);
    import pbrle_pkg::*;

    function automatic close_t close_group(enc_state_t s, logic [7:0] v, logic [7:0] c);
        close_t           r;
        logic [7:0]       ll;
        logic [POS_W-1:0] hdr;
        logic [POS_W-1:0] wp;
        r   = '0;
        r.st = s;
        ll  = s.literal_length;
        hdr = s.literal_header_pos;
        wp  = s.write_pos;
        if (c > 8'd1)
        begin
            // run: header is (257 - count) mod 256
            r.w0.out_pos  = wp;
            r.w0.out_byte = 8'd1 - c;
            r.w1.out_pos  = wp + POS_W'(1);
            r.w1.out_byte = v;
            r.st.write_pos      = wp + POS_W'(2);
            r.st.coding_mode    = MODE_RUN;
            r.st.literal_length = 8'd0;
        end
        else
        begin
            if (s.coding_mode == MODE_LITERAL)
            begin
                ll = s.literal_length + 8'd1;
                if (ll > RUN_MAX)
                begin
                    // literal full: leave room for a fresh header
                    hdr = wp;
                    wp  = wp + POS_W'(1);
                    ll  = ll - RUN_MAX;
                end
            end
            else
            begin
                hdr = wp;
                ll  = 8'd1;
                wp  = wp + POS_W'(1);
                r.st.coding_mode = MODE_LITERAL;
            end
            r.w0.out_pos  = hdr;
            r.w0.out_byte = ll - 8'd1;
            r.w1.out_pos  = wp;
            r.w1.out_byte = v;
            r.st.write_pos          = wp + POS_W'(1);
            r.st.literal_length     = ll;
            r.st.literal_header_pos = hdr;
        end
        return r;
    endfunction

    logic       pending;
    logic       hit;
    close_t     close_a;
    close_t     close_b;
    enc_state_t mid;

    assign pending = (cur.group_count != 8'd0);
    assign hit     = pending && (item.in_byte == cur.group_value);

    always_comb
    begin
        nxt     = cur;
        res     = '0;
        close_a = '0;
        close_b = '0;
        mid     = cur;
        if (!item.in_last)
        begin
            if (hit)
            begin
                if (cur.group_count >= RUN_MAX)
                begin
                    close_a = close_group(cur, cur.group_value, RUN_MAX);
                    nxt = close_a.st;
                    nxt.group_count = 8'd1;
                    res.wr[0] = close_a.w0;
                    res.wr[1] = close_a.w1;
                    res.num   = 3'd2;
                end
                else
                begin
                    nxt.group_count = cur.group_count + 8'd1;
                end
            end
            else
            begin
                if (pending)
                begin
                    close_a = close_group(cur, cur.group_value, cur.group_count);
                    nxt = close_a.st;
                    res.wr[0] = close_a.w0;
                    res.wr[1] = close_a.w1;
                    res.num   = 3'd2;
                end
                nxt.group_value = item.in_byte;
                nxt.group_count = 8'd1;
            end
        end
        else
        begin
            // final byte always forms its own group; state returns to reset
            if (pending)
            begin
                close_a = close_group(cur, cur.group_value, cur.group_count);
                mid = close_a.st;
            end
            close_b = close_group(mid, item.in_byte, 8'd1);
            if (pending)
            begin
                res.wr[0] = close_a.w0;
                res.wr[1] = close_a.w1;
                res.wr[2] = close_b.w0;
                res.wr[3] = close_b.w1;
                res.wr[3].out_last = 1'b1;
                res.num = 3'd4;
            end
            else
            begin
                res.wr[0] = close_b.w0;
                res.wr[1] = close_b.w1;
                res.wr[1].out_last = 1'b1;
                res.num = 3'd2;
            end
            nxt = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/packbits_rle_encoder_core.sv
// PackBits run-length encoder top level: input register, encoder state,
// result buffer and output channel. Depends on pbrle_pkg and pbrle_step.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------
//  in      | in  | in_valid/in_ready  | in_item  (in_byte, in_last)
//  out     | out | out_valid/out_ready| out_item (out_pos, out_byte, out_last)
//
// Each byte is held in the input register and then encoded combinationally
// as it loads into a four-entry result buffer. The buffer drains one write
// per cycle while out_ready is high. A byte yields no write, two writes when
// it closes a run or literal group, or four for a final byte that closes one.
// Reset clears the encoder state and both valid flags. The input register
// is reloaded as the buffer hands out its last write, so out_ready stalls
// propagate to in_ready only once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module packbits_rle_encoder_core (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire pbrle_pkg::in_item_t in_item,
    output logic                     out_valid,
    input  wire                      out_ready,
    output pbrle_pkg::out_item_t     out_item
);
    import pbrle_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    enc_state_t state_reg;
    enc_state_t state_next;
    step_res_t  step_res;
    out_item_t  res_reg [4];
    logic [1:0] rd_reg;
    logic [2:0] left_reg;
    logic       pop;
    logic       load;

    pbrle_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign out_valid = (left_reg != 3'd0);
    assign out_item  = res_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign load      = in_valid_reg && ((left_reg == 3'd0) || ((left_reg == 3'd1) && out_ready));
    assign in_ready  = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            rd_reg       <= 2'd0;
            left_reg     <= 3'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;

            if (load)
            begin
                state_reg <= state_next;
                rd_reg    <= 2'd0;
                left_reg  <= step_res.num;
            end
            else if (pop)
            begin
                rd_reg   <= rd_reg + 2'd1;
                left_reg <= left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
        if (load)
        begin
            for (int i = 0; i < 4; i++)
                res_reg[i] <= step_res.wr[i];
        end
    end

endmodule

`default_nettype wire

### bench/pbrle_write_checker.sv
// Write checker for the PackBits encoder core: watches both channels, predicts
// the positioned writes for every accepted input word and compares them in order.
// Depends on pbrle_pkg.
`timescale 1ns / 1ps

module pbrle_write_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  pbrle_pkg::in_item_t  in_item,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  pbrle_pkg::out_item_t out_item,
    output int                   fail_count,
    output int                   backlog
);
    import pbrle_pkg::*;

    // Predictor state
    logic [7:0]       grp_val;
    logic [7:0]       grp_cnt;
    mode_t            cur_mode;
    logic [7:0]       lit_len;
    logic [POS_W-1:0] lit_hdr;
    logic [POS_W-1:0] wpos;

    out_item_t step_wr [4];
    int        step_n;
    out_item_t queued_writes [$];
    out_item_t exp_w;

    function void clear_state();
        grp_val  = '0;
        grp_cnt  = '0;
        cur_mode = MODE_BASE;
        lit_len  = '0;
        lit_hdr  = '0;
        wpos     = '0;
    endfunction

    function void add_write(input logic [POS_W-1:0] pos, input logic [7:0] val);
        if (step_n < 4)
        begin
            step_wr[step_n] = {pos, val, 1'b0};
            step_n++;
        end
    endfunction

    // header is (257 - count) mod 256, i.e. 1 - count in eight bits
    function void put_run(input logic [7:0] v, input logic [7:0] c);
        add_write(wpos, 8'd1 - c);
        add_write(wpos + POS_W'(1), v);
        wpos     = wpos + POS_W'(2);
        cur_mode = MODE_RUN;
        lit_len  = '0;
    endfunction

    function void close_group(input logic [7:0] v, input logic [7:0] c);
        if (c > 8'd1)
            put_run(v, c);
        else
        begin
            if (cur_mode == MODE_LITERAL)
            begin
                lit_len = lit_len + 8'd1;
                // literal full: skip a slot for a fresh header
                if (lit_len > RUN_MAX)
                begin
                    lit_hdr = wpos;
                    wpos    = wpos + POS_W'(1);
                    lit_len = lit_len - RUN_MAX;
                end
            end
            else
            begin
                lit_hdr  = wpos;
                lit_len  = 8'd1;
                wpos     = wpos + POS_W'(1);
                cur_mode = MODE_LITERAL;
            end
            add_write(lit_hdr, lit_len - 8'd1);
            add_write(wpos, v);
            wpos = wpos + POS_W'(1);
        end
    endfunction

    function void predict_writes(input logic [7:0] b, input logic last);
        step_n = 0;
        if (!last)
        begin
            if (grp_cnt != 8'd0 && b == grp_val)
            begin
                if (grp_cnt >= RUN_MAX)
                begin
                    put_run(grp_val, RUN_MAX);
                    grp_cnt = 8'd1;
                end
                else
                    grp_cnt = grp_cnt + 8'd1;
            end
            else
            begin
                if (grp_cnt != 8'd0)
                    close_group(grp_val, grp_cnt);
                grp_val = b;
                grp_cnt = 8'd1;
            end
        end
        else
        begin
            // final byte always stands as a group of its own
            if (grp_cnt != 8'd0)
                close_group(grp_val, grp_cnt);
            close_group(b, 8'd1);
            step_wr[step_n-1].out_last = 1'b1;
            clear_state();
        end
        for (int i = 0; i < step_n; i++)
            queued_writes.push_back(step_wr[i]);
    endfunction

    initial
    begin
        clear_state();
        fail_count = 0;
        backlog    = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_state();
            queued_writes.delete();
            backlog <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (queued_writes.size() == 0)
                begin
                    $error("unexpected word: out_pos %0d out_byte %02h out_last %0d",
                           out_item.out_pos, out_item.out_byte, out_item.out_last);
                    fail_count++;
                end
                else
                begin
                    exp_w = queued_writes.pop_front();
                    if (out_item.out_pos !== exp_w.out_pos)
                    begin
                        $error("out_pos: expected %0d, got %0d",
                               exp_w.out_pos, out_item.out_pos);
                        fail_count++;
                    end
                    if (out_item.out_byte !== exp_w.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               exp_w.out_byte, out_item.out_byte);
                        fail_count++;
                    end
                    if (out_item.out_last !== exp_w.out_last)
                    begin
                        $error("out_last: expected %0d, got %0d",
                               exp_w.out_last, out_item.out_last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_writes(in_item.in_byte, in_item.in_last);
            backlog <= queued_writes.size();
        end
    end

endmodule

### bench/tb_packbits_rle_encoder_core.sv
// Top of the PackBits encoder bench: clock, reset, byte streams and verdict.
// Depends on pbrle_pkg, packbits_rle_encoder_core and pbrle_write_checker.
`timescale 1ns / 1ps

module tb_packbits_rle_encoder_core;
    import pbrle_pkg::*;

    localparam int RANDOM_BYTES = 270;
    localparam int TAIL_CYCLES  = 20;

    typedef enum int {
        SEG_RUN,
        SEG_LITERAL,
        SEG_NOISE,
        SEG_LONG_RUN,
        SEG_LONG_LITERAL
    } seg_kind_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    int        fail_count;
    int        backlog;

    int sent;
    bit calm;
    bit long_run_done;
    bit long_lit_done;
    int stall_left;

    packbits_rle_encoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    pbrle_write_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one; none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(2) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        in_item  <= {b, last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one stream of runs, literals and noise, closed by a final word
    task automatic send_stream();
        logic [7:0] q [$];
        logic [7:0] v;
        logic [7:0] alt;
        seg_kind_t  kind;
        int         nseg;
        int         len;
        int         r;
        nseg = $urandom_range(1, 6);
        for (int s = 0; s < nseg; s++)
        begin
            r = $urandom_range(9);
            if (!long_run_done && sent >= 60)
            begin
                kind = SEG_LONG_RUN;
                long_run_done = 1'b1;
            end
            else if (!long_lit_done && sent >= 180)
            begin
                kind = SEG_LONG_LITERAL;
                long_lit_done = 1'b1;
            end
            else if (r < 4)
                kind = SEG_RUN;
            else if (r < 7)
                kind = SEG_LITERAL;
            else
                kind = SEG_NOISE;

            v = (q.size() != 0) ? q[$] : 8'($urandom_range(255));
            case (kind)
                SEG_RUN, SEG_LONG_RUN:
                begin
                    len = (kind == SEG_RUN) ? $urandom_range(2, 9) : $urandom_range(128, 136);
                    v   = 8'($urandom_range(255));
                    repeat (len) q.push_back(v);
                end
                SEG_LITERAL, SEG_LONG_LITERAL:
                begin
                    len = (kind == SEG_LITERAL) ? $urandom_range(1, 8)
                                                : $urandom_range(129, 136);
                    repeat (len)
                    begin
                        v = v + 8'($urandom_range(1, 255));
                        q.push_back(v);
                    end
                end
                default:
                begin
                    v   = 8'($urandom_range(255));
                    alt = 8'($urandom_range(255));
                    len = $urandom_range(1, 8);
                    repeat (len) q.push_back($urandom_range(1) ? v : alt);
                end
            endcase
        end
        // at times a final word repeating the one before it
        if ($urandom_range(3) == 0)
            q.push_back(q[$]);
        for (int i = 0; i < q.size(); i++)
            push_byte(q[i], i == q.size() - 1);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        out_ready  <= 1'b0;
        stall_left = 0;
        sent       = 0;
        calm       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone final word
        push_byte(8'h00, 1'b1);
        // final word equal to the one before: never merged
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        // run closed by a different final word
        push_byte(8'hA5, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);
        // literal, run, literal
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b1);
        // two-word run then equal final word
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b1);
        // alternating extremes
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);

        sent          = 0;
        long_run_done = 1'b0;
        long_lit_done = 1'b0;
        while (sent < RANDOM_BYTES)
        begin
            calm = ($urandom_range(4) == 0);
            send_stream();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
